FILE: rtl/core/dtwg_pkg.sv
// Shared types, constants and tables of the depth to gray window and gamma mapper.
package dtwg_pkg;

  localparam logic [16:0] Q16_ONE     = 17'h10000;
  localparam logic [31:0] NARROW_WIDEN = 32'd66;
  localparam logic [15:0] GAMMA_UNITY = 16'd4096;
  localparam int          FIFO_DEPTH  = 2;
  localparam int          FIFO_AW     = $clog2(FIFO_DEPTH);

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_SCAN  = 2'd1,
    FUNC_MAP   = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_RANGE_LOW  = 2'd0,
    CFG_RANGE_HIGH = 2'd1,
    CFG_GAMMA      = 2'd2,
    CFG_INVERT     = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    B_IDLE, B_RECIP, B_MUL, B_WIN, B_LOG, B_ESTART, B_EDIV, B_EXP, B_SCALE, B_DONE
  } back_state_t;

  // One map transaction as the back end needs it.
  typedef struct packed {
    logic signed [31:0] depth;
    logic               finite;
    logic [31:0]        lo;
    logic [31:0]        span;
    logic               need_recip;
  } map_item_t;

  typedef struct packed {
    logic [15:0] gamma;
    logic        invert;
  } back_cfg_t;

  typedef logic [30:0] fac_tab_t [16];

  function automatic logic [63:0] isqrt64(input logic [63:0] xin);
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bitv;
    x    = xin;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Factors 2^(-2^-i), i = 1..16, in Q1.30, by repeated square roots of one half.
  function automatic fac_tab_t exp_tab_build();
    fac_tab_t    tab;
    logic [63:0] s;
    s = 64'd1 << 29;
    for (int i = 0; i < 16; i++) begin
      s      = isqrt64(s << 30);
      tab[i] = s[30:0];
    end
    return tab;
  endfunction

  localparam fac_tab_t EXP_TAB = exp_tab_build();

endpackage

FILE: rtl/core/dtwg_fifo.sv
// Short queue of map transactions between the front and the back end.
module dtwg_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dtwg_pkg::map_item_t push_data,
  input  logic                pop,
  output dtwg_pkg::map_item_t pop_data,
  output logic                full,
  output logic                empty
);
  import dtwg_pkg::*;

  map_item_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;

  assign full     = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && !full) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop && !empty) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if ((push && !full) && !(pop && !empty)) begin
      count_nxt = count_r + 1'b1;
    end else if (!(push && !full) && (pop && !empty)) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/core/dtwg_front.sv
// Front end: configuration registers, range tracking and window setup per transaction.
module dtwg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_func,
  input  logic signed [31:0]  in_depth,
  input  logic                in_finite,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                q_full,
  output logic                q_push,
  output dtwg_pkg::map_item_t q_data,
  output dtwg_pkg::back_cfg_t bcfg
);
  import dtwg_pkg::*;

  logic signed [31:0] range_low_r, range_high_r;
  logic [15:0]        gamma_r;
  logic               invert_r;
  logic signed [31:0] seen_min_r, seen_max_r;
  logic               seen_any_r;
  logic               recip_ok_r, recip_ok_nxt;

  logic               accept;
  logic [31:0]        lo, hi;
  logic [32:0]        hi_minus_lo;
  logic [31:0]        span;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept && (func_t'(in_func) == FUNC_MAP);
  assign bcfg     = '{gamma: gamma_r, invert: invert_r};

  // All bounds in use are non-negative, so plain unsigned compares serve.
  always_comb begin
    lo = !range_low_r[31] ? range_low_r : (seen_any_r ? seen_min_r : 32'd0);
    hi = !range_high_r[31] ? range_high_r : (seen_any_r ? seen_max_r : 32'(Q16_ONE));
    hi_minus_lo = {1'b0, hi} - {1'b0, lo};
    span = (hi <= lo) ? NARROW_WIDEN : hi_minus_lo[31:0];
  end

  // The cached reciprocal stays good across map and func 3 transactions; clear, scan and register writes drop it.
  always_comb begin
    recip_ok_nxt = recip_ok_r;
    if (accept) begin
      case (func_t'(in_func))
        FUNC_CLEAR, FUNC_SCAN: recip_ok_nxt = 1'b0;
        FUNC_MAP:              recip_ok_nxt = 1'b1;
        default:               ;
      endcase
    end
    if (cfg_valid) begin
      recip_ok_nxt = 1'b0;
    end
  end

  assign q_data = '{depth: in_depth, finite: in_finite, lo: lo, span: span,
                    need_recip: !recip_ok_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= -32'sd65536;
      range_high_r <= -32'sd65536;
      gamma_r      <= GAMMA_UNITY;
      invert_r     <= 1'b0;
      seen_min_r   <= 32'sh7FFF_FFFF;
      seen_max_r   <= 32'sh8000_0000;
      seen_any_r   <= 1'b0;
      recip_ok_r   <= 1'b0;
    end else begin
      recip_ok_r <= recip_ok_nxt;
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_RANGE_LOW:  range_low_r  <= cfg_data;
          CFG_RANGE_HIGH: range_high_r <= cfg_data;
          CFG_GAMMA:      gamma_r      <= cfg_data[15:0];
          CFG_INVERT:     invert_r     <= cfg_data[0];
          default:        invert_r     <= invert_r;
        endcase
      end
      if (accept) begin
        case (func_t'(in_func))
          FUNC_CLEAR: begin
            seen_min_r <= 32'sh7FFF_FFFF;
            seen_max_r <= 32'sh8000_0000;
            seen_any_r <= 1'b0;
          end
          FUNC_SCAN: begin
            if (in_finite && in_depth > 0) begin
              if (in_depth < seen_min_r) seen_min_r <= in_depth;
              if (in_depth > seen_max_r) seen_max_r <= in_depth;
              seen_any_r <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: rtl/core/dtwg_div.sv
// Restoring divider, one quotient bit per cycle, 33-bit dividend by 32-bit divisor.
module dtwg_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [32:0] quotient
);
  import dtwg_pkg::*;

  logic [31:0] rem_r;
  logic [32:0] num_r, quo_r;
  logic [31:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] trial;
  logic        take;
  logic [32:0] diff;

  assign trial    = {rem_r, num_r[32]};
  assign take     = trial >= {1'b0, den_r};
  assign diff     = trial - {1'b0, den_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd32;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      num_r <= dividend;
      den_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? diff[31:0] : trial[31:0];
      num_r <= {num_r[31:0], 1'b0};
      quo_r <= {quo_r[31:0], take};
    end
  end

endmodule

FILE: rtl/core/dtwg_back.sv
// Back end: reciprocal, window product, log2/exp2 power curve and output register.
module dtwg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  dtwg_pkg::map_item_t q_data,
  input  logic                q_empty,
  output logic                q_pop,
  input  dtwg_pkg::back_cfg_t bcfg,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_gray
);
  import dtwg_pkg::*;

  back_state_t state_r, state_nxt;
  map_item_t   item_r;
  logic [31:0] recip_r;
  logic [63:0] prod_r;
  logic [16:0] t_r;
  logic [30:0] m_r;
  logic [15:0] frac_r;
  logic [3:0]  p_r;
  logic [3:0]  cnt_r;
  logic [20:0] e_r;
  logic [30:0] acc_r;
  logic        out_valid_r;
  logic [7:0]  out_gray_r;

  logic               div_start, div_done;
  logic [32:0]        div_dvd, div_q;
  logic [31:0]        div_dsr;
  logic signed [32:0] diff;
  logic               win_hi, win_lo;
  logic [63:0]        t_sum;
  logic [16:0]        t_win, t_sel;
  logic               pow_on;
  logic [3:0]         p;
  logic [30:0]        m_init;
  logic [61:0]        m_sq;
  logic [20:0]        mag;
  logic [32:0]        ediv_dvd;
  logic [61:0]        acc_prod;
  logic [61:0]        acc_rnd;
  logic [4:0]         k;
  logic [32:0]        y_sum, y;
  logic [16:0]        t_out;
  logic [24:0]        gray_sum;
  logic               out_load;

  dtwg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    diff   = {item_r.depth[31], item_r.depth} - $signed({1'b0, item_r.lo});
    win_hi = !item_r.finite || (diff >= $signed({1'b0, item_r.span}));
    win_lo = (diff <= 0);
    t_sum  = prod_r + 64'd32768;
    t_win  = (t_sum[63:16] > 48'(Q16_ONE)) ? Q16_ONE : t_sum[32:16];
    t_sel  = win_hi ? Q16_ONE : (win_lo ? 17'd0 : t_win);
    pow_on = (bcfg.gamma != 16'd0) && (bcfg.gamma != GAMMA_UNITY) &&
             (t_sel != 17'd0) && (t_sel != Q16_ONE);
    p = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (t_sel[i]) p = 4'(i);
    end
    m_init   = 31'(t_sel[15:0]) << (5'd30 - {1'b0, p});
    m_sq     = m_r * m_r;
    mag      = {(5'd16 - {1'b0, p_r}), 16'd0} - {5'd0, frac_r};
    ediv_dvd = {mag, 12'd0} + {18'd0, bcfg.gamma[15:1]};
    acc_prod = acc_r * EXP_TAB[cnt_r];
    acc_rnd  = (acc_prod + 62'(32'h2000_0000)) >> 30;
    k        = e_r[20:16];
    y_sum    = {2'b0, acc_r} + (33'd1 << (5'd13 + k));
    y        = y_sum >> (6'd14 + {1'b0, k});
    t_out    = bcfg.invert ? (Q16_ONE - t_r) : t_r;
    gray_sum = (25'(t_out) << 8) - 25'(t_out) + 25'd32768;
    out_load = (state_r == B_DONE) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_dvd   = ediv_dvd;
    div_dsr   = {16'd0, bcfg.gamma};
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.need_recip) begin
            div_start = 1'b1;
            div_dvd   = 33'h1_0000_0000;
            div_dsr   = q_data.span;
            state_nxt = B_RECIP;
          end else begin
            state_nxt = B_MUL;
          end
        end
      end
      B_RECIP:  if (div_done) state_nxt = B_MUL;
      B_MUL:    state_nxt = B_WIN;
      B_WIN:    state_nxt = pow_on ? B_LOG : B_DONE;
      B_LOG:    if (cnt_r == 4'd0) state_nxt = B_ESTART;
      B_ESTART: begin
        div_start = 1'b1;
        state_nxt = B_EDIV;
      end
      B_EDIV: begin
        if (div_done) state_nxt = (div_q[32:16] > 17'd16) ? B_DONE : B_EXP;
      end
      B_EXP:    if (cnt_r == 4'd15) state_nxt = B_SCALE;
      B_SCALE:  state_nxt = B_DONE;
      B_DONE:   if (out_load) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE:  if (!q_empty) item_r <= q_data;
      B_RECIP: if (div_done) recip_r <= div_q[32] ? 32'hFFFF_FFFF : div_q[31:0];
      B_MUL:   prod_r <= 64'(diff[31:0]) * 64'(recip_r);
      B_WIN: begin
        t_r    <= t_sel;
        m_r    <= m_init;
        p_r    <= p;
        frac_r <= '0;
        cnt_r  <= 4'd15;
      end
      B_LOG: begin
        if (m_sq[61]) begin
          m_r           <= m_sq[61:31];
          frac_r[cnt_r] <= 1'b1;
        end else begin
          m_r <= m_sq[60:30];
        end
        cnt_r <= cnt_r - 1'b1;
      end
      B_EDIV: begin
        if (div_done) begin
          t_r   <= '0;
          e_r   <= div_q[20:0];
          acc_r <= 31'h4000_0000;
          cnt_r <= 4'd0;
        end
      end
      B_EXP: begin
        if (e_r[4'd15 - cnt_r]) acc_r <= acc_rnd[30:0];
        cnt_r <= cnt_r + 1'b1;
      end
      B_SCALE: t_r <= (y > 33'(Q16_ONE)) ? Q16_ONE : y[16:0];
      B_DONE:  if (out_load) out_gray_r <= gray_sum[23:16];
      default: t_r <= t_r;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_gray  = out_gray_r;

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == B_RECIP) || (state_r == B_EDIV))
    else $error("divider finished outside a wait state");
  a_log_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_LOG) |-> m_r[30])
    else $error("log mantissa lost normalization");
  a_exp_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EXP) |-> (acc_r <= 31'h4000_0000))
    else $error("exp accumulator above one");
  a_t_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DONE) |-> (t_r <= Q16_ONE))
    else $error("window value above one");

endmodule

FILE: rtl/core/depth_to_gray_window_gamma.sv
// Top level of the depth to gray window and gamma mapper.
// Usage: a frame goes through in two passes. A clear transaction (func 0) resets the
// found depth range, range-scan transactions (func 1) fold finite positive samples into
// the running minimum and maximum, and map transactions (func 2) turn a sample into an
// 8-bit gray level on the out_ channel. Only map transactions produce a result.
// The in_ and out_ channels use valid and stall: a transaction moves on a rising edge with
// valid high and stall low. The cfg_ port writes range_low, range_high, gamma_value and
// invert_output by index and is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this. The front end takes one transaction a
// cycle into a two-entry queue while the queue is not full. The back end works on one map
// transaction at a time, through B_IDLE, B_MUL, B_WIN and B_DONE for a plain window; the
// first map after a range or register change adds a 33-step reciprocal divide, and the
// gamma curve, when on, adds 16 log squarings, a 33-step divide by gamma and 16 exp
// products. Both divides use the shared divider.
// After reset the registers hold their defaults and the found range is empty.
// When the receiver stalls, the result waits in the output register; the back end then
// holds its next result, the queue fills and in_stall rises.
module depth_to_gray_window_gamma (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic signed [31:0] in_depth,
  input  logic               in_finite,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_gray,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import dtwg_pkg::*;

  map_item_t push_data, pop_data;
  back_cfg_t bcfg;
  logic      q_push, q_pop, q_full, q_empty;

  // Register writes never wait.
  assign cfg_ready = 1'b1;

  dtwg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .in_depth  (in_depth),
    .in_finite (in_finite),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data),
    .bcfg      (bcfg)
  );

  dtwg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  dtwg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (pop_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .bcfg      (bcfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_gray  (out_gray)
  );

endmodule
